// ===== sv/i2c_master_byte_write_unit_assert.svh =====
// Assertion macros for the top-level file of this block.
`ifndef I2C_MASTER_BYTE_WRITE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_WRITE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define I2CBW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cbw same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define I2CBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cbw next-cycle check failed");

`endif

// ===== sv/i2cbw_pkg.sv =====
package i2cbw_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 2'd1;

    localparam logic [7:0] DEV_ADDR_RESET = 8'd120;
    localparam logic [7:0] PHASE_RESET    = 8'd10;

    localparam logic [4:0] START_LAST  = 5'd2;
    localparam logic [4:0] BIT_PHASES  = 5'd24;
    localparam logic [4:0] ACK_HIGH    = 5'd26;
    localparam logic [4:0] BYTE_LAST   = 5'd27;
    localparam logic [4:0] STOP_LAST   = 5'd2;
    localparam logic [1:0] SUB_HIGH    = 2'd2;
    localparam logic [1:0] BYTE_ADDR   = 2'd0;
    localparam logic [1:0] BYTE_CTRL   = 2'd1;
    localparam logic [1:0] BYTE_DATA   = 2'd2;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_REQ  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ctrl_byte;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q2b;

    typedef struct packed {
        logic [7:0] dev_addr;
        logic [7:0] phase_ticks;
    } t_cfg;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       busy_res;
        logic       accepted;
        logic       done_res;
        logic [2:0] ack_status;
    } t_res;

endpackage

// ===== sv/i2c_master_byte_write_unit.sv =====
// A tick beat is stored in the tick queue, then its result beat is registered by the sequencer.
// Throughput: one tick beat per cycle unless stalled; the bus state advances once per beat.
// A transfer spans 90 bus phases of max(phase_ticks, 1) tick beats each.
// Reset clears the tick queue, the sequencer and the status, and loads the address
// and phase length registers with 120 and 10.
`include "i2c_master_byte_write_unit_assert.svh"

module i2c_master_byte_write_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [7:0]                      i_ctrl_byte,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_sda_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_scl_level,
    output logic                            o_sda_level,
    output logic                            o_sda_released,
    output logic                            o_busy_res,
    output logic                            o_accepted,
    output logic                            o_done_res,
    output logic [2:0]                      o_ack_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [i2cbw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);

    i2cbw_pkg::t_cfg r_cfg;
    i2cbw_pkg::t_q2b w_head;
    i2cbw_pkg::t_res w_res;
    logic            w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dev_addr    <= i2cbw_pkg::DEV_ADDR_RESET;
            r_cfg.phase_ticks <= i2cbw_pkg::PHASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == i2cbw_pkg::CFG_DEV_ADDR) begin
                r_cfg.dev_addr <= i_cfg_data;
            end else if (i_cfg_index == i2cbw_pkg::CFG_PHASE) begin
                r_cfg.phase_ticks <= i_cfg_data;
            end
        end
    end

    i2cbw_front #(
        .DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_req_type (i_req_type),
        .i_ctrl_byte(i_ctrl_byte),
        .i_data_byte(i_data_byte),
        .i_sda_in   (i_sda_in),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    i2cbw_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_pop  (w_pop),
        .i_cfg  (r_cfg),
        .o_valid(o_out_valid),
        .i_stall(i_out_stall),
        .o_res  (w_res)
    );

    assign o_scl_level    = w_res.scl_level;
    assign o_sda_level    = w_res.sda_level;
    assign o_sda_released = w_res.sda_released;
    assign o_busy_res     = w_res.busy_res;
    assign o_accepted     = w_res.accepted;
    assign o_done_res     = w_res.done_res;
    assign o_ack_status   = w_res.ack_status;

    `I2CBW_ASSERT_NOW(a_accept_clears_ack, i_clk, i_rst_n, o_out_valid && o_accepted, o_busy_res && (o_ack_status == 3'd0) && !o_done_res)
    `I2CBW_ASSERT_NOW(a_release_high, i_clk, i_rst_n, o_out_valid && o_sda_released, o_sda_level && o_busy_res && !o_done_res)
    `I2CBW_ASSERT_NOW(a_done_in_stop, i_clk, i_rst_n, o_out_valid && o_done_res, o_busy_res && o_scl_level && o_sda_level)
    `I2CBW_ASSERT_NEXT(a_stall_holds_result, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(w_res))

endmodule

// ===== sv/i2cbw_front.sv =====
module i2cbw_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_req_type,
    input  logic [7:0]      i_ctrl_byte,
    input  logic [7:0]      i_data_byte,
    input  logic            i_sda_in,
    output i2cbw_pkg::t_q2b o_head,
    input  logic            i_pop
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    i2cbw_pkg::t_item r_buf [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wp;
    logic [PW-1:0]    n_rp;
    logic [CW-1:0]    n_cnt;
    i2cbw_pkg::t_item w_item;
    logic             w_push;
    logic             w_pop;

    assign o_stall = (r_cnt == CW'(DEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_cnt != '0);

    always_comb begin
        w_item.kind      = i_req_type ? i2cbw_pkg::KIND_REQ : i2cbw_pkg::KIND_TICK;
        w_item.ctrl_byte = i_ctrl_byte;
        w_item.data_byte = i_data_byte;
        w_item.sda_in    = i_sda_in;
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_buf[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        unique case ({w_push, w_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_buf[r_wp] <= w_item;
        end
    end

endmodule

// ===== sv/i2cbw_back.sv =====
module i2cbw_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  i2cbw_pkg::t_q2b i_head,
    output logic            o_pop,
    input  i2cbw_pkg::t_cfg i_cfg,
    output logic            o_valid,
    input  logic            i_stall,
    output i2cbw_pkg::t_res o_res
);

    typedef enum logic [1:0] {
        RG_START,
        RG_BYTE,
        RG_STOP
    } t_region;

    logic            r_active;
    t_region         r_region;
    logic [4:0]      r_pos;
    logic [1:0]      r_sub;
    logic [1:0]      r_byte;
    logic [7:0]      r_tick;
    logic [7:0]      r_shift;
    logic [7:0]      r_lctrl;
    logic [7:0]      r_ldata;
    logic [2:0]      r_ack;
    logic            r_sda_prev;
    logic            r_valid;
    i2cbw_pkg::t_res r_res;

    logic            n_active;
    t_region         n_region;
    logic [4:0]      n_pos;
    logic [1:0]      n_sub;
    logic [1:0]      n_byte;
    logic [7:0]      n_tick;
    logic [7:0]      n_shift;
    logic [2:0]      n_ack;
    logic            n_sda_prev;
    i2cbw_pkg::t_res n_res;

    logic            w_take;
    logic            w_acc;
    logic            c_active;
    t_region         c_region;
    logic [4:0]      c_pos;
    logic [1:0]      c_sub;
    logic [1:0]      c_byte;
    logic [7:0]      c_tick;
    logic [7:0]      c_shift;
    logic [2:0]      c_ack;
    logic [8:0]      w_span;
    logic            w_last;
    logic            w_scl;
    logic            w_sda;
    logic            w_rel;
    logic            w_done;

    assign w_take = i_head.valid && (!r_valid || !i_stall);
    assign o_pop  = w_take;
    assign w_acc  = !r_active && (i_head.item.kind == i2cbw_pkg::KIND_REQ);

    always_comb begin
        c_active = r_active || w_acc;
        c_region = w_acc ? RG_START : r_region;
        c_pos    = w_acc ? '0 : r_pos;
        c_sub    = w_acc ? '0 : r_sub;
        c_byte   = w_acc ? '0 : r_byte;
        c_tick   = w_acc ? '0 : r_tick;
        c_shift  = w_acc ? i_cfg.dev_addr : r_shift;
        c_ack    = w_acc ? '0 : r_ack;
        w_span   = (i_cfg.phase_ticks == '0) ? 9'd1 : {1'b0, i_cfg.phase_ticks};
        w_last   = (({1'b0, c_tick} + 9'd1) >= w_span);
    end

    always_comb begin
        n_active   = c_active;
        n_region   = c_region;
        n_pos      = c_pos;
        n_sub      = c_sub;
        n_byte     = c_byte;
        n_tick     = c_tick;
        n_shift    = c_shift;
        n_ack      = c_ack;
        w_scl      = 1'b1;
        w_sda      = 1'b1;
        w_rel      = 1'b0;
        w_done     = 1'b0;
        if (c_active) begin
            n_tick = w_last ? '0 : c_tick + 1'b1;
            unique case (c_region)
                RG_START: begin
                    w_scl = (c_pos < i2cbw_pkg::START_LAST);
                    w_sda = (c_pos == '0);
                    if (w_last) begin
                        if (c_pos == i2cbw_pkg::START_LAST) begin
                            n_region = RG_BYTE;
                            n_pos    = '0;
                            n_sub    = '0;
                            n_byte   = i2cbw_pkg::BYTE_ADDR;
                        end else begin
                            n_pos = c_pos + 1'b1;
                        end
                    end
                end
                RG_BYTE: begin
                    if (c_pos < i2cbw_pkg::BIT_PHASES) begin
                        w_scl = (c_sub == i2cbw_pkg::SUB_HIGH);
                        w_sda = (c_sub == '0) ? r_sda_prev : c_shift[7];
                        if (w_last) begin
                            if (c_sub == i2cbw_pkg::SUB_HIGH) begin
                                n_shift = {c_shift[6:0], 1'b0};
                                n_sub   = '0;
                            end else begin
                                n_sub = c_sub + 1'b1;
                            end
                        end
                    end else if (c_pos == i2cbw_pkg::BIT_PHASES) begin
                        w_scl = 1'b0;
                        w_sda = r_sda_prev;
                    end else begin
                        w_rel = 1'b1;
                        w_sda = 1'b1;
                        w_scl = (c_pos == i2cbw_pkg::ACK_HIGH);
                        if ((c_pos == i2cbw_pkg::ACK_HIGH) && w_last) begin
                            unique case (c_byte)
                                i2cbw_pkg::BYTE_ADDR: n_ack[0] = c_ack[0] | i_head.item.sda_in;
                                i2cbw_pkg::BYTE_CTRL: n_ack[1] = c_ack[1] | i_head.item.sda_in;
                                i2cbw_pkg::BYTE_DATA: n_ack[2] = c_ack[2] | i_head.item.sda_in;
                                default:              n_ack    = c_ack;
                            endcase
                        end
                        if ((c_pos == i2cbw_pkg::BYTE_LAST) && w_last) begin
                            if (c_byte == i2cbw_pkg::BYTE_ADDR) begin
                                n_shift = r_lctrl;
                            end else if (c_byte == i2cbw_pkg::BYTE_CTRL) begin
                                n_shift = r_ldata;
                            end
                        end
                    end
                    if (w_last) begin
                        if (c_pos == i2cbw_pkg::BYTE_LAST) begin
                            n_pos = '0;
                            n_sub = '0;
                            if (c_byte == i2cbw_pkg::BYTE_DATA) begin
                                n_region = RG_STOP;
                            end else begin
                                n_byte = c_byte + 1'b1;
                            end
                        end else begin
                            n_pos = c_pos + 1'b1;
                        end
                    end
                end
                RG_STOP: begin
                    w_scl  = (c_pos != '0);
                    w_sda  = (c_pos >= i2cbw_pkg::STOP_LAST);
                    w_done = (c_pos == i2cbw_pkg::STOP_LAST) && w_last;
                    if (w_last) begin
                        if (c_pos == i2cbw_pkg::STOP_LAST) begin
                            n_active = 1'b0;
                            n_region = RG_START;
                            n_pos    = '0;
                        end else begin
                            n_pos = c_pos + 1'b1;
                        end
                    end
                end
                default: begin
                    n_region = RG_START;
                end
            endcase
        end
        n_sda_prev         = c_active ? w_sda : 1'b1;
        n_res.scl_level    = w_scl;
        n_res.sda_level    = w_sda;
        n_res.sda_released = w_rel;
        n_res.busy_res     = c_active;
        n_res.accepted     = w_acc;
        n_res.done_res     = w_done;
        n_res.ack_status   = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_region   <= RG_START;
            r_pos      <= '0;
            r_sub      <= '0;
            r_byte     <= '0;
            r_tick     <= '0;
            r_ack      <= '0;
            r_sda_prev <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            if (w_take) begin
                r_active   <= n_active;
                r_region   <= n_region;
                r_pos      <= n_pos;
                r_sub      <= n_sub;
                r_byte     <= n_byte;
                r_tick     <= n_tick;
                r_ack      <= n_ack;
                r_sda_prev <= n_sda_prev;
                r_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (w_take) begin
            r_shift <= n_shift;
            r_res   <= n_res;
            if (w_acc) begin
                r_lctrl <= i_head.item.ctrl_byte;
                r_ldata <= i_head.item.data_byte;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== sim/i2c_master_byte_write_unit_tb.sv =====
`timescale 1ns / 100ps

module i2c_master_byte_write_unit_tb;

    localparam int RESET_CYCLES     = 7;
    localparam int SETTLE_CYCLES    = 6;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int RANDOM_BEATS     = 790;
    localparam int CALM_BEATS       = 150;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DIRECTED_COUNT   = 16;

    localparam int unsigned START_PHASES = 3;
    localparam int unsigned BYTE_SPAN    = 28;
    localparam int unsigned BIT_SUBS     = 3;
    localparam int unsigned STOP_FIRST   = 87;
    localparam int unsigned LAST_PHASE   = 89;

    localparam logic [i2cbw_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [i2cbw_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        i2cbw_pkg::t_item stim;
        logic             typed;
        i2cbw_pkg::t_res  want;
    } t_tick_beat;

    localparam i2cbw_pkg::t_res IDLE_LEVELS = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0};
    localparam i2cbw_pkg::t_res START_TAKEN = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 3'd0};
    localparam i2cbw_pkg::t_res START_HELD  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0};
    localparam i2cbw_pkg::t_res UNTYPED     = '0;

    localparam t_tick_beat DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{'{i2cbw_pkg::KIND_TICK, 8'h00, 8'h00, 1'b0}, 1'b1, IDLE_LEVELS},
        '{'{i2cbw_pkg::KIND_TICK, 8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_LEVELS},
        '{'{i2cbw_pkg::KIND_TICK, 8'h55, 8'hAA, 1'b0}, 1'b1, IDLE_LEVELS},
        '{'{i2cbw_pkg::KIND_REQ,  8'hFF, 8'h00, 1'b1}, 1'b1, START_TAKEN},
        '{'{i2cbw_pkg::KIND_REQ,  8'h00, 8'hFF, 1'b0}, 1'b1, START_HELD},
        '{'{i2cbw_pkg::KIND_REQ,  8'hAA, 8'h55, 1'b1}, 1'b1, START_HELD},
        '{'{i2cbw_pkg::KIND_TICK, 8'h0F, 8'hF0, 1'b0}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'hF0, 8'h0F, 1'b1}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_REQ,  8'h81, 8'h7E, 1'b0}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'h7E, 8'h81, 1'b1}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'h00, 8'h00, 1'b0}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'hFF, 8'hFF, 1'b1}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'h33, 8'hCC, 1'b0}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_REQ,  8'hCC, 8'h33, 1'b1}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'h12, 8'h34, 1'b0}, 1'b0, UNTYPED},
        '{'{i2cbw_pkg::KIND_TICK, 8'hED, 8'hCB, 1'b1}, 1'b0, UNTYPED}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_req_type = 1'b0;
    logic [7:0]                      i_ctrl_byte = '0;
    logic [7:0]                      i_data_byte = '0;
    logic                            i_sda_in = 1'b0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic                            o_scl_level;
    logic                            o_sda_level;
    logic                            o_sda_released;
    logic                            o_busy_res;
    logic                            o_accepted;
    logic                            o_done_res;
    logic [2:0]                      o_ack_status;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [i2cbw_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]                      i_cfg_data = '0;

    i2c_master_byte_write_unit dut (.*);

    // Predictor state and register copies.
    logic [7:0] cfg_dev_addr = i2cbw_pkg::DEV_ADDR_RESET;
    logic [7:0] cfg_phase_ticks = i2cbw_pkg::PHASE_RESET;
    logic [6:0] bus_phase = '0;
    logic [7:0] tick_cnt = '0;
    logic [7:0] shift_q = '0;
    logic [7:0] ctrl_hold = '0;
    logic [7:0] data_hold = '0;
    logic [2:0] ack_q = '0;
    logic       xfer_active = 1'b0;
    logic       sda_last = 1'b1;

    t_tick_beat      ticks_to_send[$];
    i2cbw_pkg::t_res pending_levels[$];
    t_tick_beat      sent_beat;
    i2cbw_pkg::t_res predicted;
    i2cbw_pkg::t_res seen;
    i2cbw_pkg::t_res wanted;

    bit calm = 1'b0;
    bit long_hold_done = 1'b0;
    int send_gap = 0;
    int stall_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int xfers_started = 0;
    int xfers_finished = 0;
    int nack_results = 0;
    int reg_writes = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic i2cbw_pkg::t_res advance_bus(input i2cbw_pkg::t_item it);
        i2cbw_pkg::t_res r;
        int unsigned     span, p, q, k, w, sub, s;
        logic            last;
        r = IDLE_LEVELS;
        if (!xfer_active && it.kind == i2cbw_pkg::KIND_REQ) begin
            xfer_active = 1'b1;
            bus_phase   = '0;
            tick_cnt    = '0;
            ctrl_hold   = it.ctrl_byte;
            data_hold   = it.data_byte;
            shift_q     = cfg_dev_addr;
            ack_q       = '0;
            r.accepted  = 1'b1;
            xfers_started++;
        end
        if (!xfer_active) begin
            sda_last     = 1'b1;
            r.ack_status = ack_q;
            return r;
        end
        span = (cfg_phase_ticks == 8'd0) ? 1 : cfg_phase_ticks;
        last = (tick_cnt + 1 >= span);
        p = bus_phase;
        r.busy_res = 1'b1;
        if (p < START_PHASES) begin
            r.scl_level = (p < i2cbw_pkg::START_LAST);
            r.sda_level = (p == 0);
        end else if (p < STOP_FIRST) begin
            q = p - START_PHASES;
            k = q / BYTE_SPAN;
            w = q % BYTE_SPAN;
            if (w < i2cbw_pkg::BIT_PHASES) begin
                sub = w % BIT_SUBS;
                r.scl_level = (sub == i2cbw_pkg::SUB_HIGH);
                r.sda_level = (sub == 0) ? sda_last : shift_q[7];
                if (sub == i2cbw_pkg::SUB_HIGH && last) shift_q = shift_q << 1;
            end else if (w == i2cbw_pkg::BIT_PHASES) begin
                r.scl_level = 1'b0;
                r.sda_level = sda_last;
            end else begin
                r.sda_released = 1'b1;
                r.scl_level    = (w == i2cbw_pkg::ACK_HIGH);
                if (w == i2cbw_pkg::ACK_HIGH && last) ack_q[k] = ack_q[k] | it.sda_in;
                if (w == i2cbw_pkg::BYTE_LAST && last) begin
                    if (k == i2cbw_pkg::BYTE_ADDR) shift_q = ctrl_hold;
                    else if (k == i2cbw_pkg::BYTE_CTRL) shift_q = data_hold;
                end
            end
        end else begin
            s = p - STOP_FIRST;
            r.scl_level = (s != 0);
            r.sda_level = (s >= i2cbw_pkg::STOP_LAST);
            r.done_res  = (p >= LAST_PHASE) && last;
        end
        if (last) begin
            tick_cnt = '0;
            if (p >= LAST_PHASE) begin
                xfer_active = 1'b0;
                bus_phase   = '0;
                xfers_finished++;
            end else begin
                bus_phase = 7'(p + 1);
            end
        end else begin
            tick_cnt = tick_cnt + 8'd1;
        end
        sda_last     = r.sda_level;
        r.ack_status = ack_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [2:0] want,
                                        input logic [2:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                sent_beat = ticks_to_send.pop_front();
                predicted = advance_bus(sent_beat.stim);
                pending_levels.push_back(sent_beat.typed ? sent_beat.want : predicted);
                beats_taken++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (ticks_to_send.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid  <= 1'b1;
                    i_req_type  <= ticks_to_send[0].stim.kind;
                    i_ctrl_byte <= ticks_to_send[0].stim.ctrl_byte;
                    i_data_byte <= ticks_to_send[0].stim.data_byte;
                    i_sda_in    <= ticks_to_send[0].stim.sda_in;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                seen = '{o_scl_level, o_sda_level, o_sda_released, o_busy_res,
                         o_accepted, o_done_res, o_ack_status};
                if (pending_levels.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %b", $time, seen);
                    mismatches++;
                end else begin
                    wanted = pending_levels.pop_front();
                    check_field("scl_level", 3'(wanted.scl_level), 3'(seen.scl_level));
                    check_field("sda_level", 3'(wanted.sda_level), 3'(seen.sda_level));
                    check_field("sda_released", 3'(wanted.sda_released),
                                3'(seen.sda_released));
                    check_field("busy_res", 3'(wanted.busy_res), 3'(seen.busy_res));
                    check_field("accepted", 3'(wanted.accepted), 3'(seen.accepted));
                    check_field("done_res", 3'(wanted.done_res), 3'(seen.done_res));
                    check_field("ack_status", wanted.ack_status, seen.ack_status);
                end
                if (seen.ack_status != 3'd0) nack_results++;
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT && i_in_valid) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [i2cbw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unique case (idx)
            i2cbw_pkg::CFG_DEV_ADDR: cfg_dev_addr = val;
            i2cbw_pkg::CFG_PHASE:    cfg_phase_ticks = val;
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic settle();
        while (ticks_to_send.size() != 0 || i_in_valid || pending_levels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_ticks(input int count, input bit lead_req, input int req_odds);
        t_tick_beat b;
        for (int i = 0; i < count; i++) begin
            b = '0;
            b.stim.kind = ((lead_req && i == 0)
                           || (req_odds != 0 && $urandom_range(1, req_odds) == 1))
                          ? i2cbw_pkg::KIND_REQ : i2cbw_pkg::KIND_TICK;
            b.stim.ctrl_byte = 8'($urandom_range(0, 255));
            b.stim.data_byte = 8'($urandom_range(0, 255));
            b.stim.sda_in    = 1'($urandom_range(0, 1));
            ticks_to_send.push_back(b);
        end
    endtask

    initial begin
        int random_left;
        int seg;
        int n;
        int pick;
        logic [7:0] phase_val;
        logic [7:0] addr_val;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_COUNT; i++) ticks_to_send.push_back(DIRECTED_ROWS[i]);
        settle();

        // A slow phase is cut short mid-phase, and the address changes under a live transfer.
        write_reg(i2cbw_pkg::CFG_PHASE, 8'd255);
        queue_ticks(41, 1'b1, 0);
        settle();
        write_reg(i2cbw_pkg::CFG_DEV_ADDR, 8'($urandom_range(0, 255)));
        write_reg(i2cbw_pkg::CFG_PHASE, 8'd1);
        queue_ticks(110, 1'b0, 12);

        random_left = RANDOM_BEATS;
        seg = 0;
        while (random_left > 0) begin
            settle();
            pick = $urandom_range(0, 9);
            if (pick <= 5) phase_val = 8'd1;
            else if (pick == 6) phase_val = 8'd0;
            else if (pick == 7) phase_val = 8'd2;
            else if (pick == 8) phase_val = 8'd3;
            else phase_val = 8'($urandom_range(4, 6));
            if (seg == 0) begin
                addr_val = 8'h00;
                phase_val = 8'd0;
            end else if (seg == 1) begin
                addr_val = 8'hFF;
            end else begin
                addr_val = 8'($urandom_range(0, 255));
            end
            write_reg(i2cbw_pkg::CFG_DEV_ADDR, addr_val);
            write_reg(i2cbw_pkg::CFG_PHASE, phase_val);
            if (seg % 3 == 2)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          8'($urandom_range(0, 255)));
            calm = (random_left <= CALM_BEATS);
            n = $urandom_range(120, 220);
            if (n > random_left) n = random_left;
            queue_ticks(n, 1'b1, 12);
            random_left -= n;
            seg++;
        end
        settle();

        $display("Run moved %0d tick beats and %0d result beats over %0d register writes.",
                 beats_taken, results_seen, reg_writes);
        $display("Transfers started %0d, finished %0d; %0d beats showed a missing ack.",
                 xfers_started, xfers_finished, nack_results);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/i2cbw_pkg.sv
sv/i2cbw_front.sv
sv/i2cbw_back.sv
sv/i2c_master_byte_write_unit.sv
sim/i2c_master_byte_write_unit_tb.sv
